// ===== hw/rtl/htca_pkg.sv =====
// ----------------------------------------------------------------------------
// htca_pkg
// Types and constants shared by the canonical code assigner modules.
// ----------------------------------------------------------------------------
package htca_pkg;

	localparam int DATA_W   = 8;
	localparam int POS_W    = 5;
	localparam int LEN_W    = 5;
	localparam int CODE_W   = 16;
	localparam int NEXT_W   = 17;
	localparam int NUM_CNT  = 16;
	localparam int IDX_W    = 4;
	localparam int CMD_DEPTH = 4;

	localparam logic [POS_W-1:0] POS_IDLE      = 5'd0;
	localparam logic [POS_W-1:0] POS_LAST_CNT  = 5'd16;
	localparam logic [POS_W-1:0] POS_SYMBOLS   = 5'd17;
	localparam logic [IDX_W-1:0] LAST_CNT_IDX  = 4'd15;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_NO_CODE  = 2'd1,
		ERR_OVERSUB  = 2'd2
	} err_kind_t;

	typedef enum logic {
		CMD_COUNT  = 1'b0,
		CMD_SYMBOL = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [IDX_W-1:0]    idx;
		logic [DATA_W-1:0]   data;
		logic                last;
	} cmd_t;

endpackage

// ===== hw/rtl/htca_front.sv =====
// ----------------------------------------------------------------------------
// htca_front
// Tracks the byte position in a table and turns count and symbol bytes
// into commands for the back end; header and stray bytes are dropped.
// ----------------------------------------------------------------------------
module htca_front
	import htca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              fifo_full,
	input  logic [DATA_W-1:0] data_byte,
	input  logic              first_byte,
	input  logic              last_byte,
	output logic              cmd_push,
	output cmd_t              cmd
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_d;
	logic             accept;

	assign accept = push && !fifo_full;

	always_comb begin
		pos_d    = pos_q;
		cmd_push = 1'b0;
		cmd.kind = CMD_COUNT;
		cmd.idx  = IDX_W'(pos_q - POS_W'(1));
		cmd.data = data_byte;
		cmd.last = last_byte;
		if (first_byte) begin
			pos_d = last_byte ? POS_IDLE : POS_W'(1);
		end else if (pos_q == POS_IDLE) begin
			pos_d = POS_IDLE;
		end else if (pos_q <= POS_LAST_CNT) begin
			cmd_push = accept;
			pos_d    = last_byte ? POS_IDLE : pos_q + POS_W'(1);
		end else begin
			cmd_push = accept;
			cmd.kind = CMD_SYMBOL;
			pos_d    = last_byte ? POS_IDLE : POS_SYMBOLS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (accept) begin
			pos_q <= pos_d;
		end
	end

endmodule

// ===== hw/rtl/htca_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// htca_cmd_fifo
// Short command queue between the front end and the code assigner.
// ----------------------------------------------------------------------------
module htca_cmd_fifo
	import htca_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic full,
	output logic empty
);

	localparam int PTR_W = $clog2(CMD_DEPTH);

	cmd_t              mem_q [CMD_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign full    = count_q == (PTR_W+1)'(CMD_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/htca_back.sv =====
// ----------------------------------------------------------------------------
// htca_back
// Stores the length counts and hands out canonical codes, stepping one
// code length per cycle past empty lengths; results go to an output register.
// ----------------------------------------------------------------------------
module htca_back
	import htca_pkg::*;
#(
	parameter int MAX_CODE_LENGTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	input  logic              pop,
	output logic              empty,
	output logic [DATA_W-1:0] symbol,
	output logic [CODE_W-1:0] code_word,
	output logic [LEN_W-1:0]  code_length,
	output logic [1:0]        error_kind,
	output logic              last
);

	logic [DATA_W-1:0] cnt_q [NUM_CNT];
	logic [LEN_W-1:0]  cur_q;
	logic [DATA_W-1:0] left_q;
	logic [NEXT_W-1:0] code_q;
	logic              out_valid_q;

	logic              skip;
	logic              out_space;
	logic              is_count;
	logic              is_symbol;
	logic              emit;
	logic              fits;

	assign is_count  = cmd_valid && (cmd.kind == CMD_COUNT);
	assign is_symbol = cmd_valid && (cmd.kind == CMD_SYMBOL);
	assign skip      = (left_q == '0) && (cur_q < LEN_W'(MAX_CODE_LENGTH));
	assign out_space = !out_valid_q || pop;
	assign emit      = is_symbol && !skip && out_space;
	assign cmd_pop   = is_count || emit;
	assign fits      = code_q < (NEXT_W'(1) << cur_q);
	assign empty     = !out_valid_q;

	always_ff @(posedge clk) begin
		if (is_count) begin
			cnt_q[cmd.idx] <= cmd.data;
		end
	end

	// after the last count, start one length below 1 so the first step loads count 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= LEN_W'(1);
			left_q <= '0;
			code_q <= '0;
		end else if (is_count) begin
			if (cmd.idx == LAST_CNT_IDX) begin
				cur_q  <= '0;
				left_q <= '0;
				code_q <= '0;
			end
		end else if (is_symbol && skip) begin
			code_q <= code_q << 1;
			cur_q  <= cur_q + LEN_W'(1);
			left_q <= cnt_q[cur_q[IDX_W-1:0]];
		end else if (emit && (left_q != '0)) begin
			left_q <= left_q - DATA_W'(1);
			if (fits) begin
				code_q <= code_q + NEXT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			symbol <= cmd.data;
			last   <= cmd.last;
			if (left_q == '0) begin
				code_word   <= '0;
				code_length <= '0;
				error_kind  <= ERR_NO_CODE;
			end else if (fits) begin
				code_word   <= code_q[CODE_W-1:0];
				code_length <= cur_q;
				error_kind  <= ERR_NONE;
			end else begin
				code_word   <= '0;
				code_length <= cur_q;
				error_kind  <= ERR_OVERSUB;
			end
		end
	end

endmodule

// ===== hw/rtl/huffman_table_code_assigner_core.sv =====
// ----------------------------------------------------------------------------
// huffman_table_code_assigner_core
// Canonical Huffman code assignment from the payload of a JPEG DHT table.
// ----------------------------------------------------------------------------
// header bytes are dropped in the front end; count bytes are stored, no result
// a symbol first takes the length steps before its code, one per cycle,
// at least one for the first symbol of a table; a result passes the
// 4-entry command queue and then the result register
// asynchronous active-low reset empties the queue and the result register;
// the count store is not cleared, every table rewrites it before use
module huffman_table_code_assigner_core
	import htca_pkg::*;
#(
	parameter int MAX_CODE_LENGTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [DATA_W-1:0] data_byte,
	input  logic              first_byte,
	input  logic              last_byte,
	output logic              empty,
	input  logic              pop,
	output logic [DATA_W-1:0] symbol,
	output logic [CODE_W-1:0] code_word,
	output logic [LEN_W-1:0]  code_length,
	output logic [1:0]        error_kind,
	output logic              last
);

	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_pop;
	logic cmd_empty;

	htca_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.fifo_full (full),
		.data_byte (data_byte),
		.first_byte(first_byte),
		.last_byte (last_byte),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	htca_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_in),
		.rd_en  (cmd_pop),
		.rd_data(cmd_head),
		.full   (full),
		.empty  (cmd_empty)
	);

	htca_back #(
		.MAX_CODE_LENGTH(MAX_CODE_LENGTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (!cmd_empty),
		.cmd        (cmd_head),
		.cmd_pop    (cmd_pop),
		.pop        (pop),
		.empty      (empty),
		.symbol     (symbol),
		.code_word  (code_word),
		.code_length(code_length),
		.error_kind (error_kind),
		.last       (last)
	);

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> code_length <= LEN_W'(MAX_CODE_LENGTH))
		else $error("code length above maximum");

	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error_kind == ERR_NO_CODE) |-> (code_length == '0 && code_word == '0))
		else $error("exhausted result carries a code");

	a_code_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error_kind == ERR_NONE) |->
		(code_length != '0 && (17'(code_word) >> code_length) == '0))
		else $error("code does not fit its length");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (error_kind == ERR_NONE || error_kind == ERR_NO_CODE ||
		error_kind == ERR_OVERSUB))
		else $error("undefined error kind");

endmodule
